@@ sv/cps_pkg.sv @@
// Shared types and constant tables for the nearest prime search core.
`default_nettype none
package cps_pkg;

    localparam int PRIME_COUNT = 303;
    localparam int PIDX_W      = 9;
    localparam int PRIME_W     = 11;
    localparam int WIT_COUNT   = 3;

    localparam logic [PRIME_W-1:0] PRIME_TABLE [PRIME_COUNT] = '{
        11'd2, 11'd3, 11'd5, 11'd7, 11'd11, 11'd13, 11'd17, 11'd19, 11'd23, 11'd29,
        11'd31, 11'd37, 11'd41, 11'd43, 11'd47, 11'd53, 11'd59, 11'd61, 11'd67,
        11'd71, 11'd73, 11'd79, 11'd83, 11'd89, 11'd97, 11'd101, 11'd103, 11'd107,
        11'd109, 11'd113, 11'd127, 11'd131, 11'd137, 11'd139, 11'd149, 11'd151,
        11'd157, 11'd163, 11'd167, 11'd173, 11'd179, 11'd181, 11'd191, 11'd193,
        11'd197, 11'd199, 11'd211, 11'd223, 11'd227, 11'd229, 11'd233, 11'd239,
        11'd241, 11'd251, 11'd257, 11'd263, 11'd269, 11'd271, 11'd277, 11'd281,
        11'd283, 11'd293, 11'd307, 11'd311, 11'd313, 11'd317, 11'd331, 11'd337,
        11'd347, 11'd349, 11'd353, 11'd359, 11'd367, 11'd373, 11'd379, 11'd383,
        11'd389, 11'd397, 11'd401, 11'd409, 11'd419, 11'd421, 11'd431, 11'd433,
        11'd439, 11'd443, 11'd449, 11'd457, 11'd461, 11'd463, 11'd467, 11'd479,
        11'd487, 11'd491, 11'd499, 11'd503, 11'd509, 11'd521, 11'd523, 11'd541,
        11'd547, 11'd557, 11'd563, 11'd569, 11'd571, 11'd577, 11'd587, 11'd593,
        11'd599, 11'd601, 11'd607, 11'd613, 11'd617, 11'd619, 11'd631, 11'd641,
        11'd643, 11'd647, 11'd653, 11'd659, 11'd661, 11'd673, 11'd677, 11'd683,
        11'd691, 11'd701, 11'd709, 11'd719, 11'd727, 11'd733, 11'd739, 11'd743,
        11'd751, 11'd757, 11'd761, 11'd769, 11'd773, 11'd787, 11'd797, 11'd809,
        11'd811, 11'd821, 11'd823, 11'd827, 11'd829, 11'd839, 11'd853, 11'd857,
        11'd859, 11'd863, 11'd877, 11'd881, 11'd883, 11'd887, 11'd907, 11'd911,
        11'd919, 11'd929, 11'd937, 11'd941, 11'd947, 11'd953, 11'd967, 11'd971,
        11'd977, 11'd983, 11'd991, 11'd997, 11'd1009, 11'd1013, 11'd1019, 11'd1021,
        11'd1031, 11'd1033, 11'd1039, 11'd1049, 11'd1051, 11'd1061, 11'd1063,
        11'd1069, 11'd1087, 11'd1091, 11'd1093, 11'd1097, 11'd1103, 11'd1109,
        11'd1117, 11'd1123, 11'd1129, 11'd1151, 11'd1153, 11'd1163, 11'd1171,
        11'd1181, 11'd1187, 11'd1193, 11'd1201, 11'd1213, 11'd1217, 11'd1223,
        11'd1229, 11'd1231, 11'd1237, 11'd1249, 11'd1259, 11'd1277, 11'd1279,
        11'd1283, 11'd1289, 11'd1291, 11'd1297, 11'd1301, 11'd1303, 11'd1307,
        11'd1319, 11'd1321, 11'd1327, 11'd1361, 11'd1367, 11'd1373, 11'd1381,
        11'd1399, 11'd1409, 11'd1423, 11'd1427, 11'd1429, 11'd1433, 11'd1439,
        11'd1447, 11'd1451, 11'd1453, 11'd1459, 11'd1471, 11'd1481, 11'd1483,
        11'd1487, 11'd1489, 11'd1493, 11'd1499, 11'd1511, 11'd1523, 11'd1531,
        11'd1543, 11'd1549, 11'd1553, 11'd1559, 11'd1567, 11'd1571, 11'd1579,
        11'd1583, 11'd1597, 11'd1601, 11'd1607, 11'd1609, 11'd1613, 11'd1619,
        11'd1621, 11'd1627, 11'd1637, 11'd1657, 11'd1663, 11'd1667, 11'd1669,
        11'd1693, 11'd1697, 11'd1699, 11'd1709, 11'd1721, 11'd1723, 11'd1733,
        11'd1741, 11'd1747, 11'd1753, 11'd1759, 11'd1777, 11'd1783, 11'd1787,
        11'd1789, 11'd1801, 11'd1811, 11'd1823, 11'd1831, 11'd1847, 11'd1861,
        11'd1867, 11'd1871, 11'd1873, 11'd1877, 11'd1879, 11'd1889, 11'd1901,
        11'd1907, 11'd1913, 11'd1931, 11'd1933, 11'd1949, 11'd1951, 11'd1973,
        11'd1979, 11'd1987, 11'd1993, 11'd1997, 11'd1999
    };

    localparam logic [6:0] WITNESS_TABLE [WIT_COUNT] = '{7'd2, 7'd7, 7'd61};

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_DIV, S_DIVW, S_MRINIT, S_MRSHIFT, S_WIT, S_WITW,
        S_POW, S_POWMW, S_POWSQ, S_POWSW, S_CHK, S_SQ, S_SQW, S_NW,
        S_PASS, S_FAIL, S_NEXT, S_DOWN, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SIDE_FIRST, SIDE_UP, SIDE_DN
    } side_t;

endpackage
`default_nettype wire

@@ sv/closest_prime_search_core.sv @@
// Top level: nearest prime search with trial division and strong-probable-prime test.
//   channel  | dir | fields
//   s_axis   | in  | tdata[31:0] = base_value
//   m_axis   | out | tdata[31:0] = prime_found
// Every modular product runs on one bit-serial multiplier.
// A candidate costs up to 303 trial remainders plus three exponentiations, each
// about 2*VALUE_WIDTH products, and the search may visit dozens of candidates.
// One request is in work at a time; the next one is taken while a result waits.
// Reset clears the controller and output valid; no memory needs clearing.
// A stalled result holds the controller in its done state until taken.
`default_nettype none
module closest_prime_search_core #(
    parameter int VALUE_WIDTH       = 32,
    parameter int SMALL_PRIME_COUNT = 303
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] base_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] prime_found
);
    import cps_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int SW    = $clog2(W + 1);
    localparam int LIMIT = (SMALL_PRIME_COUNT > PRIME_COUNT) ? PRIME_COUNT :
                           ((SMALL_PRIME_COUNT < 1) ? 1 : SMALL_PRIME_COUNT);

    state_t            state_reg, state_next;
    side_t             side_reg, side_next;
    logic [W-1:0]      base_reg, base_next;
    logic [W-1:0]      cand_reg, cand_next;
    logic [W:0]        offset_reg, offset_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;
    logic [W-1:0]      d_reg, d_next;
    logic [SW-1:0]     s_reg, s_next;
    logic [1:0]        w_reg, w_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      sq_reg, sq_next;
    logic [W-1:0]      e_reg, e_next;
    logic [SW-1:0]     r_reg, r_next;
    logic [W-1:0]      res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;

    logic              mm_start, mm_busy, mm_done;
    logic [W-1:0]      mm_a, mm_b, mm_m, mm_r;
    logic [W-1:0]      prime_cur, cand_m1, in_base;
    logic [W:0]        up_sum;
    logic              in_accept, out_load;

    assign prime_cur = W'(PRIME_TABLE[idx_reg]);
    assign cand_m1   = cand_reg - 1'b1;
    assign up_sum    = {1'b0, base_reg} + offset_reg;
    assign in_base   = s_axis_tdata[W-1:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    cps_modmul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (mm_m),
        .busy  (mm_busy),
        .done  (mm_done),
        .r     (mm_r)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (s_axis_tvalid) state_next = (in_base == W'(2)) ? S_DONE : S_START;
            S_START:   state_next = (cand_reg <= W'(1)) ? S_PASS : S_DIV;
            S_DIV:     state_next = (cand_reg == prime_cur) ? S_PASS : S_DIVW;
            S_DIVW:
                if (mm_done)
                begin
                    if (mm_r == '0)
                        state_next = S_FAIL;
                    else if (idx_reg == PIDX_W'(LIMIT - 1))
                        state_next = S_MRINIT;
                    else
                        state_next = S_DIV;
                end
            S_MRINIT:  state_next = S_MRSHIFT;
            S_MRSHIFT: if (d_reg[0]) state_next = S_WIT;
            S_WIT:     state_next = S_WITW;
            S_WITW:    if (mm_done) state_next = (mm_r == '0) ? S_NW : S_POW;
            S_POW:
                if (e_reg == '0)
                    state_next = S_CHK;
                else
                    state_next = e_reg[0] ? S_POWMW : S_POWSQ;
            S_POWMW:   if (mm_done) state_next = S_POWSQ;
            S_POWSQ:   state_next = S_POWSW;
            S_POWSW:   if (mm_done) state_next = S_POW;
            S_CHK:     state_next = (acc_reg == W'(1) || acc_reg == cand_m1) ? S_NW : S_SQ;
            S_SQ:      state_next = (r_reg < s_reg) ? S_SQW : S_FAIL;
            S_SQW:     if (mm_done) state_next = (mm_r == cand_m1) ? S_NW : S_SQ;
            S_NW:      state_next = (w_reg == 2'(WIT_COUNT - 1)) ? S_PASS : S_WIT;
            S_PASS:    state_next = S_DONE;
            S_FAIL:    state_next = (side_reg == SIDE_UP) ? S_DOWN : S_NEXT;
            S_NEXT:
                if (offset_reg >= {1'b0, base_reg})
                    state_next = S_DONE;
                else
                    state_next = up_sum[W] ? S_DOWN : S_START;
            S_DOWN:    state_next = S_START;
            S_DONE:    if (out_load) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs to the multiplier and the input handshake
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        mm_start      = 1'b0;
        mm_a          = acc_reg;
        mm_b          = W'(1);
        mm_m          = cand_reg;
        case (state_reg)
            S_DIV:
            begin
                mm_start = (cand_reg != prime_cur);
                mm_a     = cand_reg;
                mm_m     = prime_cur;
            end
            S_WIT:
            begin
                mm_start = 1'b1;
                mm_a     = W'(WITNESS_TABLE[w_reg]);
            end
            S_POW:
            begin
                mm_start = (e_reg != '0) && e_reg[0];
                mm_b     = sq_reg;
            end
            S_POWSQ:
            begin
                mm_start = 1'b1;
                mm_a     = sq_reg;
                mm_b     = sq_reg;
            end
            S_SQ:
            begin
                mm_start = (r_reg < s_reg);
                mm_b     = acc_reg;
            end
            default:
            begin
                mm_start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        side_next      = side_reg;
        base_next      = base_reg;
        cand_next      = cand_reg;
        offset_next    = offset_reg;
        idx_next       = idx_reg;
        d_next         = d_reg;
        s_next         = s_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        e_next         = e_reg;
        r_next         = r_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
                if (in_accept)
                begin
                    base_next = in_base | W'(1);
                    cand_next = in_base | W'(1);
                    side_next = SIDE_FIRST;
                    res_next  = W'(2);
                end
            S_START:   idx_next = '0;
            S_DIVW:    if (mm_done) idx_next = idx_reg + 1'b1;
            S_MRINIT:
            begin
                d_next = cand_m1;
                s_next = '0;
            end
            S_MRSHIFT:
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                    w_next = '0;
            S_WITW:
                if (mm_done)
                begin
                    acc_next = W'(1);
                    sq_next  = mm_r;
                    e_next   = d_reg;
                end
            S_POWMW:   if (mm_done) acc_next = mm_r;
            S_POWSW:
                if (mm_done)
                begin
                    sq_next = mm_r;
                    e_next  = e_reg >> 1;
                end
            S_CHK:     r_next = SW'(1);
            S_SQW:
                if (mm_done)
                begin
                    acc_next = mm_r;
                    r_next   = r_reg + 1'b1;
                end
            S_NW:      w_next = w_reg + 1'b1;
            S_PASS:    res_next = cand_reg;
            S_FAIL:
                if (side_reg == SIDE_FIRST)
                    offset_next = (W + 1)'(2);
                else if (side_reg == SIDE_DN)
                    offset_next = offset_reg + (W + 1)'(2);
            S_NEXT:
                if (offset_reg >= {1'b0, base_reg})
                    res_next = W'(1);
                else if (!up_sum[W])
                begin
                    cand_next = up_sum[W-1:0];
                    side_next = SIDE_UP;
                end
            S_DOWN:
            begin
                cand_next = base_reg - offset_reg[W-1:0];
                side_next = SIDE_DN;
            end
            S_DONE:
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 32'(res_reg);
                end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg     <= side_next;
        base_reg     <= base_next;
        cand_reg     <= cand_next;
        offset_reg   <= offset_next;
        idx_reg      <= idx_next;
        d_reg        <= d_next;
        s_reg        <= s_next;
        w_reg        <= w_next;
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        e_reg        <= e_next;
        r_reg        <= r_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_busy)
        else $error("multiplier started while busy");
    a_trial_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (idx_reg < PIDX_W'(LIMIT)))
        else $error("trial index past table limit");
    a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_axis_tdata != 32'd0))
        else $error("zero result loaded");
`endif
endmodule
`default_nettype wire

@@ sv/cps_modmul.sv @@
// Bit-serial modular multiplier: r = a * b mod m, one bit of a per cycle.
`default_nettype none
module cps_modmul #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] m,
    output logic              busy,
    output logic              done,
    output logic [W-1:0]      r
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W+1:0]  acc_reg, acc_next;
    logic [W+1:0]  t1, t2, t3, mx;

    always_comb
    begin
        // acc < m, so 2*acc + b < 3*m: two conditional subtracts reduce it
        mx = {2'b00, m_reg};
        t1 = {acc_reg[W:0], 1'b0} + (a_reg[W-1] ? {2'b00, b_reg} : '0);
        t2 = (t1 >= mx) ? t1 - mx : t1;
        t3 = (t2 >= mx) ? t2 - mx : t2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            a_next    = a;
            b_next    = b;
            m_next    = m;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = t3;
            a_next   = {a_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign r    = acc_reg[W-1:0];
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for the nearest prime search core: a self-checking stream test.
`timescale 1ns / 1ps
`default_nettype none

class prime_scoreboard;
    logic [31:0] expected_primes[$];
    int          mismatches;
    int          requests;
    int          results;

    static int unsigned trial_primes[$];

    function new();
        mismatches = 0;
        requests   = 0;
        results    = 0;
    endfunction

    // Compute a to the power e, mod n, with 64-bit products.
    static function longint unsigned pow_mod(longint unsigned a, longint unsigned e,
                                             longint unsigned n);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % n;
        sq  = a % n;
        while (e != 0) begin
            if (e[0])
                acc = (acc * sq) % n;
            sq = (sq * sq) % n;
            e  = e >> 1;
        end
        return acc;
    endfunction

    // Primes below 2000 by a sieve-free scan, built once.
    static function void build_trial_primes();
        bit composite;
        for (int unsigned p = 2; p < 2000; p++) begin
            composite = 0;
            foreach (trial_primes[k])
                if (!composite && trial_primes[k] * trial_primes[k] <= p
                    && p % trial_primes[k] == 0)
                    composite = 1;
            if (!composite)
                trial_primes.push_back(p);
        end
    endfunction

    static function bit prime_test(longint unsigned n);
        int unsigned     witnesses[3];
        longint unsigned d;
        longint unsigned x;
        longint unsigned a;
        int              s;
        bit              passed;
        if (n <= 1)
            return 1;
        if (trial_primes.size() == 0)
            build_trial_primes();
        foreach (trial_primes[k]) begin
            if (n == trial_primes[k])
                return 1;
            if (n % trial_primes[k] == 0)
                return 0;
        end
        d = n - 1;
        s = 0;
        while (d[0] == 0) begin
            d = d >> 1;
            s++;
        end
        witnesses = '{2, 7, 61};
        foreach (witnesses[w]) begin
            a = witnesses[w] % n;
            if (a == 0)
                continue;
            x = pow_mod(a, d, n);
            if (x == 1 || x == n - 1)
                continue;
            passed = 0;
            for (int r = 1; r < s && !passed; r++) begin
                x = (x * x) % n;
                if (x == n - 1)
                    passed = 1;
            end
            if (!passed)
                return 0;
        end
        return 1;
    endfunction

    static function logic [31:0] nearest_prime(logic [31:0] base_value);
        longint unsigned center;
        longint unsigned up;
        longint unsigned down;
        if (base_value == 32'd2)
            return 32'd2;
        center = base_value | 32'd1;
        if (prime_test(center))
            return center[31:0];
        for (longint unsigned offset = 2; offset < center; offset += 2) begin
            up = center + offset;
            // Skip an upper candidate that wraps past 32 bits.
            if (up <= 64'hFFFF_FFFF && prime_test(up))
                return up[31:0];
            down = center - offset;
            if (prime_test(down))
                return down[31:0];
        end
        return 32'd1;
    endfunction

    function void note_request(logic [31:0] base_value);
        expected_primes.push_back(nearest_prime(base_value));
        requests++;
    endfunction

    function void check_result(logic [31:0] prime_found);
        logic [31:0] want;
        results++;
        if (expected_primes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result %0d", prime_found);
            return;
        end
        want = expected_primes.pop_front();
        if (want !== prime_found) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: prime_found expected %0d got %0d", want, prime_found);
        end
    endfunction

    function int pending();
        return expected_primes.size();
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    prime_scoreboard primes;
    int              sender_idle_pct;
    int              receiver_idle_pct;
    int              hold_request;
    int              hold_left;

    closest_prime_search_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        primes = new();
    end

    // Watch both channels at the edge.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            primes.note_request(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            primes.check_result(m_axis_tdata);
    end

    // Receiver: random stalls, plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic send_base(logic [31:0] base_value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= base_value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic go_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_base();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return $urandom_range(65535);
        else if (pick < 85)
            return $urandom;
        else
            return 32'hFFFF_FFFF - $urandom_range(2000);
    endfunction

    task automatic run_random(int count);
        repeat (count)
            send_base(random_base());
    endtask

    initial
    begin
        logic [31:0] directed_bases[$];
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        m_axis_tready     = 1'b0;
        hold_request      = 0;
        hold_left         = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        rst_n             = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero and one, two, small odd/even, top of range where the upper side wraps,
        // values near the end of the division table, and products of large primes.
        directed_bases = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd24,
                           32'd1997, 32'd1999, 32'd2000, 32'd2003, 32'd4012009,
                           32'd25326001, 32'd65536, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFB,
                           32'hAAAA_AAAA, 32'h5555_5555};
        foreach (directed_bases[i])
            send_base(directed_bases[i]);

        sender_idle_pct   = 20;
        receiver_idle_pct = 88;
        run_random(25);
        go_quiet();

        // Drain, then block the output long enough for the core to stall its input.
        while (primes.pending() != 0)
            @(posedge clk);
        hold_request = 20000;
        repeat (4)
            send_base($urandom_range(255));
        go_quiet();
        // Drain fully before the next phase.
        while (primes.pending() != 0)
            @(posedge clk);

        sender_idle_pct   = 88;
        receiver_idle_pct = 20;
        run_random(25);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(25);
        go_quiet();

        while (primes.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Covered %0d requests and %0d results: small, full-range and top-of-range bases,",
                 primes.requests, primes.results);
        $display("with random stalls on both sides, a long output hold and a full drain.");
        if (primes.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(64'd3_000_000_000);
        $display("Timeout with %0d results still outstanding", primes.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire

@@ files.f @@
sv/cps_pkg.sv
sv/cps_modmul.sv
sv/closest_prime_search_core.sv
verif/tb_top.sv
